// ===== design/sacn_pkg.sv =====
// ----------------------------------------------------------------------------
// sacn_pkg
// Shared widths, register map and reset values for the set-associative
// cache lookup with not-recently-used replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package sacn_pkg;

  // Stream payload widths.
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 40;
  localparam int MISS_W       = 32;

  // Configuration port.
  localparam int APB_DATA_W   = 32;
  localparam int PADDR_W      = 3;
  localparam int OFFSET_W     = 4;
  localparam int MASK_W       = 32;

  // Register reset values.
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(4);
  localparam logic [MASK_W-1:0]   MASK_RESET   = MASK_W'(15);

  // Register selected by word address bit 2.
  typedef enum logic {
    REG_OFFSET_BITS = 1'b0,
    REG_INDEX_MASK  = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== design/sacn_ram.sv =====
// ----------------------------------------------------------------------------
// sacn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sacn_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                    wdata_i,
  input  wire logic                                re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a read at the address being written returns the old row.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/sacn_set_map.sv =====
// ----------------------------------------------------------------------------
// sacn_set_map
// Reduces a gathered index modulo the number of sets through one register
// stage, loaded on enabled edges.
// ----------------------------------------------------------------------------
`default_nettype none

module sacn_set_map #(
  parameter int ADDR_BITS = 32,
  parameter int SETS      = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  en_i,
  input  wire logic [ADDR_BITS-1:0]                  idx_i,
  output logic      [(SETS > 1 ? $clog2(SETS) : 1)-1:0] set_o
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  generate
    if ((SETS & (SETS - 1)) == 0) begin : g_pow2
      localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);

      logic [SET_W-1:0] low_q;

      // Power-of-two set count: keep the low index bits.
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          low_q <= SET_W'(idx_i);
        end
      end

      assign set_o = low_q & SET_MASK;
    end else begin : g_recip
      localparam int L  = $clog2(SETS);
      localparam int PW = 2 * ADDR_BITS + L + 1;
      localparam logic [63:0] RECIP = (64'd1 << (ADDR_BITS + L)) / 64'(SETS);

      logic [PW-1:0]        prod_q;
      logic [L:0]           lo_q;
      logic [ADDR_BITS:0]   quo;
      logic [L:0]           qs;
      logic [L:0]           rem;
      logic [L:0]           rem_adj;

      // First stage: quotient estimate by reciprocal multiplication.
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q <= PW'(idx_i) * PW'(RECIP);
          lo_q   <= (L + 1)'(idx_i);
        end
      end

      // Second stage: the estimate is low by at most one, so the remainder
      // stays below twice the set count and needs one correction.
      always_comb begin
        quo     = prod_q[PW-1:ADDR_BITS+L];
        qs      = (L + 1)'((L + 1)'(quo) * (L + 1)'(SETS));
        rem     = lo_q - qs;
        rem_adj = (rem >= (L + 1)'(SETS)) ? rem - (L + 1)'(SETS) : rem;
      end

      assign set_o = rem_adj[L-1:0];
    end
  endgenerate

endmodule

`default_nettype wire

// ===== design/set_assoc_cache_nru_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_nru_lookup
// Set-associative cache tag lookup with not-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the s_axis channel carries one byte address. The block drops
//   offset_bits low bits, gathers the set index from the block address with
//   index_mask (lowest selected bit most significant) and uses the remaining
//   bits as the tag. Each reference gives one beat on m_axis with the hit flag
//   and the saturating miss count including this reference.
//   One beat is accepted per cycle unless a result waits to be taken. The
//   stages are: input register, index/tag gather, set reduction, tag RAM
//   read plus way compare, result register. Consecutive references to the
//   same set are served through a one-row write bypass.
//   When the result register holds a beat that is not taken, the whole pipe
//   holds and s_axis_tready is low; it is high whenever the output is empty.
//   Reset clears the valid marks, sets all replace marks and zeroes the miss
//   counter. The tag RAM is not cleared: an entry is only compared once its
//   valid mark is set, so no clearing pass is needed.
//   Registers must be written over APB while no reference is in flight (not enforced here).
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_nru_lookup #(
  parameter int ADDR_BITS = 32,
  parameter int SETS      = 16,
  parameter int WAYS      = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Reference stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [sacn_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [31:0] address
  // Result stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [sacn_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [0] hit, [32:1] miss_total
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sacn_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [sacn_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [sacn_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  import sacn_pkg::*;

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TAG_W = ADDR_BITS;
  localparam int ROW_W = WAYS * TAG_W;
  localparam int POS_W = $clog2(ADDR_BITS + 1);
  localparam int SUM_W = $clog2(ADDR_BITS + (1 << OFFSET_W));

  // Configuration registers.
  logic [OFFSET_W-1:0] offset_bits_q;
  logic [MASK_W-1:0]   index_mask_q;
  reg_idx_e            reg_sel;

  // Pipeline control.
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;
  logic commit;

  // Pipeline payload.
  logic [ADDR_BITS-1:0] addr1_q;
  logic [ADDR_BITS-1:0] idx2_q, tag2_q, tag3_q, tag4_q;
  logic [ADDR_BITS-1:0] idx_c, tag_c;
  logic [SET_W-1:0]     set_c, set4_q;

  // Lookup state.
  logic [SETS-1:0][WAYS-1:0] valid_q;
  logic [SETS-1:0][WAYS-1:0] repl_q;
  logic [MISS_W-1:0]         miss_q;

  // Write bypass for back-to-back references to one set.
  logic             wr_vld_q;
  logic [SET_W-1:0] wr_set_q;
  logic [ROW_W-1:0] wr_row_q;

  // Stage C signals.
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  row_eff, row_new;
  logic [WAYS-1:0]   vrow, rrow, hit_vec, hit_oh, repl_oh, fill_oh;
  logic [WAYS-1:0]   valid_new, repl_new;
  logic              hit_c, repl_none;
  logic [MISS_W-1:0] miss_next;

  // Result register.
  logic              out_vld_q;
  logic              hit_q;
  logic [MISS_W-1:0] total_q;

  // --------------------------------------------------------------------------
  // Configuration port: word address bit 2 selects the register.
  // --------------------------------------------------------------------------
  assign reg_sel = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFFSET_RESET;
      index_mask_q  <= MASK_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_OFFSET_BITS: offset_bits_q <= pwdata[OFFSET_W-1:0];
        REG_INDEX_MASK:  index_mask_q  <= pwdata[MASK_W-1:0];
        default:         offset_bits_q <= offset_bits_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_OFFSET_BITS: prdata = APB_DATA_W'(offset_bits_q);
      REG_INDEX_MASK:  prdata = APB_DATA_W'(index_mask_q);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: everything moves unless a result waits to be taken.
  // --------------------------------------------------------------------------
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign commit        = adv && v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      addr1_q <= s_axis_tdata[ADDR_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Gather: each selected bit lands at the count of selected bits above it,
  // each tag bit at the count of tag bits above it.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [ADDR_BITS-1:0] blk;
    logic [ADDR_BITS-1:0] sel_vec;
    logic [ADDR_BITS-1:0] tsel_vec;
    logic [POS_W-1:0]     ipos;
    logic [POS_W-1:0]     tpos;
    blk      = ADDR_BITS'(addr1_q >> offset_bits_q);
    sel_vec  = '0;
    tsel_vec = '0;
    idx_c    = '0;
    tag_c    = '0;
    for (int i = 0; i < ADDR_BITS; i++) begin
      if ((SUM_W'(i) + SUM_W'(offset_bits_q)) < SUM_W'(ADDR_BITS)) begin
        sel_vec[i]  = index_mask_q[i];
        tsel_vec[i] = !index_mask_q[i];
      end
    end
    for (int i = 0; i < ADDR_BITS; i++) begin
      ipos = POS_W'($countones(sel_vec >> (i + 1)));
      tpos = POS_W'($countones(tsel_vec >> (i + 1)));
      if (sel_vec[i]) begin
        idx_c = idx_c | (ADDR_BITS'(blk[i]) << ipos);
      end
      if (tsel_vec[i]) begin
        tag_c = tag_c | (ADDR_BITS'(blk[i]) << tpos);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      idx2_q <= idx_c;
      tag2_q <= tag_c;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      set4_q <= set_c;
    end
  end

  // Set reduction; its output addresses the tag RAM.
  sacn_set_map #(
    .ADDR_BITS (ADDR_BITS),
    .SETS      (SETS)
  ) u_set_map (
    .clk_i (clk_i),
    .en_i  (adv),
    .idx_i (idx2_q),
    .set_o (set_c)
  );

  // Tag RAM: one row holds the tags of all ways of a set.
  sacn_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (commit && !hit_c),
    .waddr_i (set4_q),
    .wdata_i (row_new),
    .re_i    (adv),
    .raddr_i (set_c),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage C: compare all ways, pick the victim, build the updated set.
  // --------------------------------------------------------------------------
  always_comb begin
    row_eff = (wr_vld_q && (wr_set_q == set4_q)) ? wr_row_q : ram_rdata;
    vrow    = valid_q[set4_q];
    rrow    = repl_q[set4_q];
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = vrow[w] && (row_eff[w*TAG_W +: TAG_W] == tag4_q);
    end
    hit_c     = |hit_vec;
    hit_oh    = hit_vec & WAYS'(~hit_vec + WAYS'(1));
    repl_none = (rrow == '0);
    repl_oh   = rrow & WAYS'(~rrow + WAYS'(1));
    fill_oh   = repl_none ? WAYS'(1) : repl_oh;

    if (hit_c) begin
      repl_new  = rrow & ~hit_oh;
      valid_new = vrow;
      miss_next = miss_q;
    end else begin
      repl_new  = (repl_none ? {WAYS{1'b1}} : rrow) & ~fill_oh;
      valid_new = vrow | fill_oh;
      miss_next = (miss_q == {MISS_W{1'b1}}) ? miss_q : miss_q + MISS_W'(1);
    end

    for (int w = 0; w < WAYS; w++) begin
      row_new[w*TAG_W +: TAG_W] = fill_oh[w] ? tag4_q : row_eff[w*TAG_W +: TAG_W];
    end
  end

  // Marks, counter and bypass control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      repl_q   <= '1;
      miss_q   <= '0;
      wr_vld_q <= 1'b0;
    end else if (adv) begin
      wr_vld_q <= v4_q && !hit_c;
      if (v4_q) begin
        valid_q[set4_q] <= valid_new;
        repl_q[set4_q]  <= repl_new;
        miss_q          <= miss_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_set_q <= set4_q;
      wr_row_q <= row_new;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q   <= hit_c;
      total_q <= miss_next;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({total_q, hit_q});

endmodule

`default_nettype wire

// ===== design/sacn_checker.sv =====
// ----------------------------------------------------------------------------
// sacn_checker
// Port-level checks for the cache lookup, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sacn_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [sacn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                             pready
);

  import sacn_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // With the result register empty the block always takes a reference.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  // A miss is always counted in its own result.
  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[MISS_W:1] != '0)
    else $error("miss reported with a zero miss count");

  // The miss count never goes down from one shown result to the next.
  a_miss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && $past(m_axis_tvalid) |->
      m_axis_tdata[MISS_W:1] >= $past(m_axis_tdata[MISS_W:1]))
    else $error("miss count decreased");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind set_assoc_cache_nru_lookup sacn_checker u_sacn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

`default_nettype wire
